// ===== design/ict_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ict_pkg
// shared constants, request codes and controller/datapath types for the
// interval containment tagger
// ----------------------------------------------------------------------------
package ict_pkg;

    localparam int NUM_CLASSES_DEF   = 3;
    localparam int MAX_INTERVALS_DEF = 4096;

    localparam int REQ_W   = 2;
    localparam int CLS_W   = 2;
    localparam int COORD_W = 31;
    localparam int TAG_W   = 3;

    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLS,
        S_EVAL,
        S_DONE
    } t_ict_state;

    typedef struct packed {
        logic do_clear;
        logic do_load;
        logic q_start;
        logic cls_next;
        logic ptr_inc;
        logic tag_eval;
        logic out_load;
    } t_ict_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             unmapped;
        logic             ptr_in;
        logic             before_start;
        logic             past_end;
        logic             last_cls;
    } t_ict_status;

endpackage

// ===== design/ict_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ict request and result channels
// valid/ready channels carrying the request and the class tag result
// ----------------------------------------------------------------------------
interface ict_req_if import ict_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [CLS_W-1:0]   class_index;
    logic [COORD_W-1:0] interval_start;
    logic [COORD_W-1:0] interval_end;
    logic [COORD_W-1:0] read_pos;
    logic [COORD_W-1:0] read_end;
    logic               read_unmapped;
    logic               mate_unmapped;

    modport source (
        output valid, req_type, class_index, interval_start, interval_end,
               read_pos, read_end, read_unmapped, mate_unmapped,
        input  ready
    );
    modport sink (
        input  valid, req_type, class_index, interval_start, interval_end,
               read_pos, read_end, read_unmapped, mate_unmapped,
        output ready
    );
endinterface

interface ict_res_if import ict_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TAG_W-1:0] class_tag;

    modport source (output valid, class_tag, input ready);
    modport sink (input valid, class_tag, output ready);
endinterface

// ===== design/ict_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ict_datapath
// interval stores, list lengths, walk pointers, compares and result register
// ----------------------------------------------------------------------------
module ict_datapath import ict_pkg::*; #(
    parameter int NUM_CLASSES   = NUM_CLASSES_DEF,
    parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ict_cmd           i_cmd,
    output t_ict_status        o_status,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [CLS_W-1:0]   i_class_index,
    input  logic [COORD_W-1:0] i_interval_start,
    input  logic [COORD_W-1:0] i_interval_end,
    input  logic [COORD_W-1:0] i_read_pos,
    input  logic [COORD_W-1:0] i_read_end,
    input  logic               i_read_unmapped,
    input  logic               i_mate_unmapped,
    output logic [TAG_W-1:0]   o_class_tag
);

    localparam int DEPTH = NUM_CLASSES * MAX_INTERVALS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(MAX_INTERVALS + 1);
    localparam int CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    logic [COORD_W-1:0] r_start_mem [DEPTH];
    logic [COORD_W-1:0] r_end_mem   [DEPTH];
    logic [COORD_W-1:0] r_rd_start;
    logic [COORD_W-1:0] r_rd_end;

    logic [LW-1:0]      r_len [NUM_CLASSES];
    logic [LW-1:0]      r_ptr [NUM_CLASSES];
    logic [CW-1:0]      r_cls;
    logic               r_first;
    logic [COORD_W-1:0] r_rpos;
    logic [COORD_W-1:0] r_rend;
    logic [TAG_W-1:0]   r_tag;
    logic [TAG_W-1:0]   r_res_tag;

    logic [CW-1:0]      sel_cls;
    logic [LW-1:0]      sel_len;
    logic [LW-1:0]      sel_ptr;
    logic               load_ok;
    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic               hit;

    assign load_ok  = (32'(i_class_index) < NUM_CLASSES)
                      && (r_len[CW'(i_class_index)] < LW'(MAX_INTERVALS));
    assign sel_cls  = i_cmd.do_load ? CW'(i_class_index) : r_cls;
    assign sel_len  = r_len[sel_cls];
    assign sel_ptr  = r_ptr[sel_cls];
    assign mem_we   = i_cmd.do_load && load_ok;
    assign mem_addr = AW'(sel_cls) * AW'(MAX_INTERVALS)
                      + (i_cmd.do_load ? AW'(sel_len) : AW'(sel_ptr));
    assign hit      = (r_rend <= r_rd_end);

    // single-port interval stores
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_start_mem[mem_addr] <= i_interval_start;
            r_end_mem[mem_addr]   <= i_interval_end;
        end
        r_rd_start <= r_start_mem[mem_addr];
        r_rd_end   <= r_end_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_len[i] <= '0;
                r_ptr[i] <= '0;
            end
            r_cls   <= '0;
            r_first <= 1'b1;
        end else begin
            if (i_cmd.do_clear) begin
                for (int i = 0; i < NUM_CLASSES; i++) begin
                    r_len[i] <= '0;
                    r_ptr[i] <= '0;
                end
            end
            if (mem_we) begin
                r_len[sel_cls] <= sel_len + LW'(1);
            end
            if (i_cmd.ptr_inc) begin
                r_ptr[sel_cls] <= sel_ptr + LW'(1);
                r_first        <= 1'b0;
            end
            if (i_cmd.q_start) begin
                r_cls   <= '0;
                r_first <= 1'b1;
            end else if (i_cmd.cls_next) begin
                r_cls   <= r_cls + CW'(1);
                r_first <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) begin
            r_rpos <= i_read_pos;
            r_rend <= i_read_end;
            r_tag  <= '0;
        end else if (i_cmd.tag_eval && hit) begin
            for (int i = 0; i < TAG_W; i++) begin
                if (i < NUM_CLASSES && 32'(r_cls) == i) begin
                    r_tag[i] <= 1'b1;
                end
            end
        end
        if (i_cmd.out_load) begin
            r_res_tag <= r_tag;
        end
    end

    always_comb begin
        o_status.req          = i_req_type;
        o_status.unmapped     = i_read_unmapped | i_mate_unmapped;
        o_status.ptr_in       = (sel_ptr < sel_len);
        o_status.before_start = r_first && (r_rpos < r_rd_start);
        o_status.past_end     = (r_rd_end < r_rpos);
        o_status.last_cls     = (r_cls == CW'(NUM_CLASSES - 1));
    end

    assign o_class_tag = r_res_tag;

endmodule

// ===== design/ict_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ict_ctrl
// request sequencer: executes clear and load, walks each class on a mapped query
// ----------------------------------------------------------------------------
module ict_ctrl import ict_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    input  t_ict_status i_status,
    output t_ict_cmd    o_cmd
);

    t_ict_state r_state;
    t_ict_state n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_status.req == REQ_QUERY) begin
                    n_state = i_status.unmapped ? S_DONE : S_CLS;
                end
            end
            S_CLS: begin
                if (i_status.ptr_in) begin
                    n_state = S_EVAL;
                end else if (i_status.last_cls) begin
                    n_state = S_DONE;
                end
            end
            S_EVAL: begin
                if (!i_status.before_start && i_status.past_end) begin
                    n_state = S_CLS;
                end else begin
                    n_state = i_status.last_cls ? S_DONE : S_CLS;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_status.req)
                        REQ_CLEAR: o_cmd.do_clear = 1'b1;
                        REQ_LOAD:  o_cmd.do_load  = 1'b1;
                        REQ_QUERY: o_cmd.q_start  = 1'b1;
                        default:   o_cmd          = '0;
                    endcase
                end
            end
            S_CLS: begin
                if (!i_status.ptr_in) begin
                    o_cmd.cls_next = 1'b1;
                end
            end
            S_EVAL: begin
                if (i_status.before_start) begin
                    o_cmd.cls_next = 1'b1;
                end else if (i_status.past_end) begin
                    o_cmd.ptr_inc = 1'b1;
                end else begin
                    o_cmd.tag_eval = 1'b1;
                    o_cmd.cls_next = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== design/interval_containment_tagger.sv =====
`timescale 1ns / 1ps
// sequence: clear and load are executed in the accept cycle; a mapped query walks each
//   class, skipping one whose walk pointer is past its list and doing a store read then
//   a compare per interval examined; the tag then goes into the result register
// requests: one request at a time; no new request is taken until a query's tag has
//   been loaded into the result register, and an unmapped query skips the walk
// reset: list lengths and walk pointers return to zero; store contents stay undefined
// ----------------------------------------------------------------------------
// interval_containment_tagger
// tags position-sorted reads with the classes whose current interval holds them
// ----------------------------------------------------------------------------
module interval_containment_tagger import ict_pkg::*; #(
    parameter int NUM_CLASSES   = NUM_CLASSES_DEF,
    parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ict_req_if.sink    i_req,
    ict_res_if.source  o_res
);

    t_ict_cmd    cmd;
    t_ict_status status;

    ict_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ict_datapath #(
        .NUM_CLASSES   (NUM_CLASSES),
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_req_type       (i_req.req_type),
        .i_class_index    (i_req.class_index),
        .i_interval_start (i_req.interval_start),
        .i_interval_end   (i_req.interval_end),
        .i_read_pos       (i_req.read_pos),
        .i_read_end       (i_req.read_end),
        .i_read_unmapped  (i_req.read_unmapped),
        .i_mate_unmapped  (i_req.mate_unmapped),
        .o_class_tag      (o_res.class_tag)
    );

endmodule

// ===== tb/interval_containment_tagger_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_containment_tagger_test
// self-checking bench for the interval containment tagger. a table of directed
// requests covers empty, exhausted and extreme lists, unmapped reads and
// ignored requests. random clear/load/query segments on sorted data follow,
// with some noise mixed in.
// every class tag transaction is compared with an in-bench model of the lists
// and walk pointers. both channels idle at random, and the result side holds
// off for a long stretch so that the request side backs up.
// ----------------------------------------------------------------------------
module interval_containment_tagger_test;
    import ict_pkg::*;

    localparam logic [REQ_W-1:0]   REQ_UNUSED = 2'd3;
    localparam logic [CLS_W-1:0]   CLS_NONE   = 2'd3;
    localparam logic [COORD_W-1:0] COORD_TOP  = '1;

    localparam int RANDOM_ITEMS = 700;
    localparam int LONG_HOLD    = 150;
    localparam int STUCK_LIMIT  = 30000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        logic [REQ_W-1:0]   kind;
        logic [CLS_W-1:0]   cls;
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
        logic [COORD_W-1:0] pos;
        logic [COORD_W-1:0] rend;
        logic               r_unm;
        logic               m_unm;
    } t_req_item;

    typedef struct packed {
        t_req_item        item;
        logic             known;
        logic [TAG_W-1:0] tag;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;

    ict_req_if req_ch ();
    ict_res_if res_ch ();

    interval_containment_tagger i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_res  (res_ch)
    );

    // model of the interval lists
    logic [COORD_W-1:0] span_lo [NUM_CLASSES_DEF][MAX_INTERVALS_DEF];
    logic [COORD_W-1:0] span_hi [NUM_CLASSES_DEF][MAX_INTERVALS_DEF];
    int unsigned        list_fill [NUM_CLASSES_DEF] = '{default: 0};
    int unsigned        walk_idx  [NUM_CLASSES_DEF] = '{default: 0};
    logic [TAG_W-1:0]   pending_tags [$];

    int  idle_pct      = 30;
    bit  hold_request  = 1'b0;
    int  holds_done    = 0;
    int  applied_count = 0;
    int  tags_checked  = 0;
    int  tags_set      = 0;
    int  mismatches    = 0;
    int  stuck_cycles  = 0;

    t_directed_row directed_rows [25] = '{
        '{'{REQ_QUERY, 2'd0, 31'd0, 31'd0, 31'd100, 31'd150, 1'b0, 1'b0}, 1'b1, 3'd0},
        '{'{REQ_LOAD, 2'd0, 31'd10, 31'd20, 31'd0, 31'd0, 1'b0, 1'b0}, 1'b0, 3'd0},
        '{'{REQ_LOAD, 2'd0, 31'd30, 31'd40, 31'd0, 31'd0, 1'b0, 1'b0}, 1'b0, 3'd0},
        '{'{REQ_LOAD, 2'd1, 31'd0, 31'd0, 31'd0, 31'd0, 1'b0, 1'b0}, 1'b0, 3'd0},
        '{'{REQ_LOAD, 2'd1, 31'd15, 31'd35, 31'd0, 31'd0, 1'b0, 1'b0}, 1'b0, 3'd0},
        '{'{REQ_LOAD, 2'd2, 31'd100, COORD_TOP, 31'd0, 31'd0, 1'b0, 1'b0}, 1'b0, 3'd0},
        '{'{REQ_LOAD, CLS_NONE, 31'd5, 31'd500, 31'd0, 31'd0, 1'b0, 1'b0}, 1'b0, 3'd0},
        '{'{REQ_UNUSED, CLS_NONE, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP, 1'b1, 1'b1},
          1'b0, 3'd0},
        '{'{REQ_QUERY, 2'd0, 31'd0, 31'd0, 31'd5, 31'd8, 1'b0, 1'b0}, 1'b0, 3'd0},
        '{'{REQ_QUERY, 2'd0, 31'd0, 31'd0, 31'd12, 31'd20, 1'b1, 1'b0}, 1'b1, 3'd0},
        '{'{REQ_QUERY, 2'd0, 31'd0, 31'd0, 31'd12, 31'd20, 1'b0, 1'b1}, 1'b1, 3'd0},
        '{'{REQ_QUERY, 2'd0, 31'd0, 31'd0, 31'd12, 31'd20, 1'b1, 1'b1}, 1'b1, 3'd0},
        '{'{REQ_QUERY, 2'd0, 31'd0, 31'd0, 31'd12, 31'd20, 1'b0, 1'b0}, 1'b0, 3'd0},
        '{'{REQ_QUERY, 2'd0, 31'd0, 31'd0, 31'd32, 31'd41, 1'b0, 1'b0}, 1'b0, 3'd0},
        '{'{REQ_QUERY, 2'd0, 31'd0, 31'd0, 31'd200, COORD_TOP, 1'b0, 1'b0}, 1'b0, 3'd0},
        '{'{REQ_QUERY, 2'd0, 31'd0, 31'd0, COORD_TOP, COORD_TOP, 1'b0, 1'b0}, 1'b1, 3'd4},
        '{'{REQ_QUERY, 2'd0, 31'd0, 31'd0, 31'd0, 31'd0, 1'b0, 1'b0}, 1'b0, 3'd0},
        '{'{REQ_CLEAR, 2'd0, 31'd0, 31'd0, 31'd0, 31'd0, 1'b0, 1'b0}, 1'b0, 3'd0},
        '{'{REQ_QUERY, 2'd0, 31'd0, 31'd0, COORD_TOP, COORD_TOP, 1'b0, 1'b0}, 1'b1, 3'd0},
        '{'{REQ_LOAD, 2'd0, COORD_TOP, COORD_TOP, 31'd0, 31'd0, 1'b0, 1'b0}, 1'b0, 3'd0},
        '{'{REQ_LOAD, 2'd1, 31'd0, COORD_TOP, 31'd0, 31'd0, 1'b0, 1'b0}, 1'b0, 3'd0},
        '{'{REQ_LOAD, 2'd2, 31'd0, 31'd0, 31'd0, 31'd0, 1'b0, 1'b0}, 1'b0, 3'd0},
        '{'{REQ_QUERY, 2'd0, 31'd0, 31'd0, 31'd0, 31'd0, 1'b0, 1'b0}, 1'b1, 3'd6},
        '{'{REQ_QUERY, 2'd0, 31'd0, 31'd0, COORD_TOP, 31'd0, 1'b0, 1'b0}, 1'b1, 3'd3},
        '{'{REQ_CLEAR, 2'd0, 31'd0, 31'd0, 31'd0, 31'd0, 1'b0, 1'b0}, 1'b0, 3'd0}
    };

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [COORD_W-1:0] rand_coord();
        logic [31:0] bits;
        bits = $urandom;
        return bits[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] clip(input longint v);
        if (v < 0) return '0;
        if (v > longint'(COORD_TOP)) return COORD_TOP;
        return v[COORD_W-1:0];
    endfunction

    function automatic t_req_item noise_item();
        t_req_item it;
        logic [31:0] bits;
        bits     = $urandom;
        it.kind  = bits[1:0];
        it.cls   = bits[3:2];
        it.r_unm = bits[4];
        it.m_unm = bits[5];
        it.lo    = rand_coord();
        it.hi    = rand_coord();
        it.pos   = rand_coord();
        it.rend  = rand_coord();
        return it;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // updates the list model; returns 1 when the request yields a class tag
    function automatic bit predict_tag(input t_req_item it, output logic [TAG_W-1:0] tag);
        int unsigned p;
        tag = '0;
        if (it.kind == REQ_CLEAR) begin
            for (int c = 0; c < NUM_CLASSES_DEF; c++) begin
                list_fill[c] = 0;
                walk_idx[c]  = 0;
            end
            return 1'b0;
        end
        if (it.kind == REQ_LOAD) begin
            if (int'(it.cls) < NUM_CLASSES_DEF && list_fill[it.cls] < MAX_INTERVALS_DEF) begin
                span_lo[it.cls][list_fill[it.cls]] = it.lo;
                span_hi[it.cls][list_fill[it.cls]] = it.hi;
                list_fill[it.cls]++;
            end
            return 1'b0;
        end
        if (it.kind != REQ_QUERY) return 1'b0;
        if (!it.r_unm && !it.m_unm) begin
            for (int c = 0; c < NUM_CLASSES_DEF; c++) begin
                p = walk_idx[c];
                if (p < list_fill[c] && it.pos >= span_lo[c][p]) begin
                    while (p < list_fill[c] && span_hi[c][p] < it.pos) p++;
                    walk_idx[c] = p;
                    if (p < list_fill[c] && it.rend <= span_hi[c][p]) tag[c] = 1'b1;
                end
            end
        end
        return 1'b1;
    endfunction

    // called and returns at a falling edge
    task automatic send_item(input t_req_item it, input logic known = 1'b0,
                             input logic [TAG_W-1:0] typed_tag = '0);
        int gap;
        logic [TAG_W-1:0] tag;
        gap = ($urandom_range(0, 99) < idle_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.req_type       <= it.kind;
        req_ch.class_index    <= it.cls;
        req_ch.interval_start <= it.lo;
        req_ch.interval_end   <= it.hi;
        req_ch.read_pos       <= it.pos;
        req_ch.read_end       <= it.rend;
        req_ch.read_unmapped  <= it.r_unm;
        req_ch.mate_unmapped  <= it.m_unm;
        req_ch.valid          <= 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        if (predict_tag(it, tag)) pending_tags = {pending_tags, (known ? typed_tag : tag)};
        if (it.kind != REQ_UNUSED && !(it.kind == REQ_LOAD && it.cls == CLS_NONE))
            applied_count++;
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [TAG_W-1:0] want,
                                   input logic [TAG_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns mismatch: %s, want %b got %b", $time, what, want, got);
    endtask

    // result side: random stalls plus the occasional long hold-off
    initial begin
        int stall_left;
        stall_left = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                stall_left   = LONG_HOLD;
                hold_request = 1'b0;
                holds_done++;
            end else if (stall_left == 0 && $urandom_range(0, 99) < idle_pct) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        logic [TAG_W-1:0] want;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                tags_checked++;
                if (res_ch.class_tag != '0) tags_set++;
                if (pending_tags.size() == 0) begin
                    report_mismatch("class tag with nothing pending", 'x, res_ch.class_tag);
                end else begin
                    want = pending_tags.pop_front();
                    if (res_ch.class_tag !== want)
                        report_mismatch("class tag", want, res_ch.class_tag);
                end
            end
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT) begin
                    $display("watchdog: %0d cycles without a transaction", stuck_cycles);
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    initial begin
        t_req_item it;
        longint    cur;
        longint    seg_base;
        int        n;
        int        random_from;

        req_ch.valid          = 1'b0;
        req_ch.req_type       = REQ_CLEAR;
        req_ch.class_index    = '0;
        req_ch.interval_start = '0;
        req_ch.interval_end   = '0;
        req_ch.read_pos       = '0;
        req_ch.read_end       = '0;
        req_ch.read_unmapped  = 1'b0;
        req_ch.mate_unmapped  = 1'b0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_item(directed_rows[r].item, directed_rows[r].known, directed_rows[r].tag);

        hold_request = 1'b1;
        random_from  = applied_count;
        while (applied_count - random_from < RANDOM_ITEMS) begin
            idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
            if (holds_done == 1 && !hold_request &&
                applied_count - random_from >= RANDOM_ITEMS / 2)
                hold_request = 1'b1;
            if ($urandom_range(0, 6) == 0) begin
                repeat (10) send_item(noise_item());
            end else begin
                it      = noise_item();
                it.kind = REQ_CLEAR;
                send_item(it);
                case ($urandom_range(0, 3))
                    0: begin
                        seg_base = 0;
                    end
                    1: begin
                        seg_base = longint'(COORD_TOP) - 150000;
                    end
                    default: begin
                        seg_base = $urandom_range(0, 32'h7FF0_0000);
                    end
                endcase
                for (int c = 0; c < NUM_CLASSES_DEF; c++) begin
                    n   = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
                    cur = seg_base;
                    repeat (n) begin
                        it      = noise_item();
                        it.kind = REQ_LOAD;
                        it.cls  = CLS_W'(c);
                        cur     = cur + $urandom_range(0, 300);
                        it.lo   = clip(cur);
                        it.hi   = clip(cur + $urandom_range(0, 400));
                        send_item(it);
                    end
                end
                cur = seg_base - $urandom_range(0, 100);
                repeat ($urandom_range(5, 25)) begin
                    it       = noise_item();
                    it.kind  = REQ_QUERY;
                    cur      = cur + $urandom_range(0, 250);
                    it.pos   = clip(cur);
                    it.rend  = clip(cur + $urandom_range(0, 500) - 40);
                    it.r_unm = ($urandom_range(0, 9) == 0);
                    it.m_unm = ($urandom_range(0, 9) == 0);
                    send_item(it);
                    if ($urandom_range(0, 19) == 0) begin
                        it      = noise_item();
                        it.kind = ($urandom_range(0, 1) == 0) ? REQ_UNUSED : REQ_LOAD;
                        it.cls  = CLS_NONE;
                        send_item(it);
                    end
                end
            end
        end
        req_ch.valid <= 1'b0;

        while (pending_tags.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d requests applied, %0d class tags checked, %0d with a bit set",
                 applied_count, tags_checked, tags_set);
        $display("summary: directed table plus sorted random segments, %0d long result hold-offs",
                 holds_done);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
